// File: rtl/vtpd_pkg.sv
// shared types and constants of the thermal video packet deframer
`timescale 1ns / 1ps

package vtpd_pkg;

    localparam int ADDR_W = 15;
    localparam int WORD_W = 16;
    localparam int ID_LINE_W = 12;
    localparam int ID_SEG_W = 3;

    localparam logic [1:0] ACT_WORD  = 2'd0;
    localparam logic [1:0] ACT_ARM   = 2'd1;
    localparam logic [1:0] ACT_ABORT = 2'd2;

    localparam logic [WORD_W-1:0]    DONT_CARE_MASK = 16'h0F00;
    localparam logic [ID_LINE_W-1:0] CHECK_LINE     = 12'd20;
    localparam logic [ID_SEG_W-1:0]  FIRST_SEG_ID   = 3'd1;

    typedef struct packed {
        logic [1:0]        action;
        logic [WORD_W-1:0] stream_word;
        logic              packet_start;
    } item_t;

    typedef struct packed {
        logic              pixel_valid;
        logic [ADDR_W-1:0] pixel_address;
        logic [WORD_W-1:0] pixel_value;
        logic              resync_request;
        logic              frame_done;
        logic              capturing;
    } result_t;

    // verdict on a packet's first word
    typedef struct packed {
        logic accept;
        logic resync;
        logic clear_line;
        logic clear_all;
    } verdict_t;

endpackage

// File: rtl/vtpd_if.sv
// request and result channel interfaces of the deframer
`timescale 1ns / 1ps

interface vtpd_item_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [vtpd_pkg::WORD_W-1:0] stream_word;
    logic                       packet_start;

    modport source (output valid, action, stream_word, packet_start, input ready);
    modport sink (input valid, action, stream_word, packet_start, output ready);
endinterface

interface vtpd_result_if;
    logic                        valid;
    logic                        ready;
    logic                        pixel_valid;
    logic [vtpd_pkg::ADDR_W-1:0] pixel_address;
    logic [vtpd_pkg::WORD_W-1:0] pixel_value;
    logic                        resync_request;
    logic                        frame_done;
    logic                        capturing;

    modport source (output valid, pixel_valid, pixel_address, pixel_value,
                    resync_request, frame_done, capturing, input ready);
    modport sink (input valid, pixel_valid, pixel_address, pixel_value,
                  resync_request, frame_done, capturing, output ready);
endinterface

// File: rtl/thermal_video_packet_deframer.sv
// top level of the thermal video packet deframer
//
//  channel   direction  handshake      payload
//  stream    in         valid/ready    action, stream_word, packet_start
//  result    out        valid/ready    pixel_valid, pixel_address, pixel_value,
//                                      resync_request, frame_done, capturing
//  cfg       in         cfg_write_en   cfg_write_data (four_segment_mode)
//
// one request a cycle sustained while the result port takes results; a request taken
// passes the request register and then the output register before its result shows
// the request register feeds the engine, whose result lands in the output register
// a stalled result holds the output register; the request register still takes
// a new request while the output register can drain in the same cycle
// reset clears all counters, capture state and the mode register
`timescale 1ns / 1ps

module thermal_video_packet_deframer #(
    parameter int PIXELS_PER_PACKET = 80,
    parameter int LINES_PER_SEGMENT = 60,
    parameter int SEGMENTS_PER_FRAME = 4,
    parameter int HEADER_WORDS = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    vtpd_item_if.sink     stream,
    vtpd_result_if.source result,
    input  logic          cfg_write_en,
    input  logic          cfg_write_data
);

    logic              s1_valid_reg;
    vtpd_pkg::item_t   s1_item_reg;
    logic              out_valid_reg;
    vtpd_pkg::result_t out_data_reg;
    vtpd_pkg::result_t engine_res;
    logic              advance;

    assign advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !s1_valid_reg || advance;

    vtpd_engine #(
        .PIXELS_PER_PACKET  (PIXELS_PER_PACKET),
        .LINES_PER_SEGMENT  (LINES_PER_SEGMENT),
        .SEGMENTS_PER_FRAME (SEGMENTS_PER_FRAME),
        .HEADER_WORDS       (HEADER_WORDS)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .item           (s1_item_reg),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .res            (engine_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (stream.ready)
            begin
                s1_valid_reg <= stream.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            s1_item_reg.action <= stream.action;
            s1_item_reg.stream_word <= stream.stream_word;
            s1_item_reg.packet_start <= stream.packet_start;
        end
        if (advance)
        begin
            out_data_reg <= engine_res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.pixel_valid = out_data_reg.pixel_valid;
    assign result.pixel_address = out_data_reg.pixel_address;
    assign result.pixel_value = out_data_reg.pixel_value;
    assign result.resync_request = out_data_reg.resync_request;
    assign result.frame_done = out_data_reg.frame_done;
    assign result.capturing = out_data_reg.capturing;

endmodule

// File: rtl/vtpd_judge.sv
// header rules applied at the first word of a packet
`timescale 1ns / 1ps

module vtpd_judge #(
    parameter int LINE_W = 6,
    parameter int SEG_W = 3
) (
    input  logic [vtpd_pkg::WORD_W-1:0] packet_id,
    input  logic                        armed,
    input  logic                        four_segment_mode,
    input  logic [LINE_W-1:0]           expected_line,
    input  logic [SEG_W-1:0]            current_segment,
    output vtpd_pkg::verdict_t          verdict
);

    logic [vtpd_pkg::ID_LINE_W-1:0] id_line;
    logic [vtpd_pkg::ID_SEG_W-1:0]  id_seg;
    logic [vtpd_pkg::ID_LINE_W-1:0] exp_line_ext;
    logic [vtpd_pkg::ID_SEG_W-1:0]  seg_id_expected;
    logic                           at_check;

    assign id_line = packet_id[vtpd_pkg::ID_LINE_W-1:0];
    assign id_seg = packet_id[vtpd_pkg::ID_LINE_W +: vtpd_pkg::ID_SEG_W];
    assign exp_line_ext = vtpd_pkg::ID_LINE_W'(expected_line);
    // segment field carries segment plus one
    assign seg_id_expected = vtpd_pkg::ID_SEG_W'(current_segment) + 3'd1;
    assign at_check = four_segment_mode && (id_line == vtpd_pkg::CHECK_LINE);

    always_comb
    begin
        verdict = '0;
        priority if (!armed)
        begin
            verdict = '0;
        end
        else if ((packet_id & vtpd_pkg::DONT_CARE_MASK) == vtpd_pkg::DONT_CARE_MASK)
        begin
            verdict = '0;
        end
        else if ((expected_line == '0) && (id_line != '0))
        begin
            verdict = '0;
        end
        else if (at_check && (current_segment == '0) && (id_seg != vtpd_pkg::FIRST_SEG_ID))
        begin
            // wrong first segment: restart the line count quietly
            verdict.clear_line = 1'b1;
        end
        else if ((id_line != exp_line_ext) || (at_check && (id_seg != seg_id_expected)))
        begin
            verdict.clear_all = 1'b1;
            verdict.resync = 1'b1;
        end
        else
        begin
            verdict.accept = 1'b1;
        end
    end

endmodule

// File: rtl/vtpd_engine.sv
// packet state, counters and per-word result logic
`timescale 1ns / 1ps

module vtpd_engine #(
    parameter int PIXELS_PER_PACKET = 80,
    parameter int LINES_PER_SEGMENT = 60,
    parameter int SEGMENTS_PER_FRAME = 4,
    parameter int HEADER_WORDS = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  vtpd_pkg::item_t   item,
    input  logic              cfg_write_en,
    input  logic              cfg_write_data,
    output vtpd_pkg::result_t res
);

    localparam int PACKET_WORDS = HEADER_WORDS + PIXELS_PER_PACKET;
    localparam int LINE_W = $clog2(LINES_PER_SEGMENT);
    localparam int SEG_W = $clog2(SEGMENTS_PER_FRAME + 1);
    localparam int WPOS_W = $clog2(PACKET_WORDS + 1);
    localparam logic [vtpd_pkg::ADDR_W-1:0] LINE_STEP =
        vtpd_pkg::ADDR_W'(PIXELS_PER_PACKET);
    localparam logic [vtpd_pkg::ADDR_W-1:0] SEG_REWIND =
        vtpd_pkg::ADDR_W'((LINES_PER_SEGMENT - 1) * PIXELS_PER_PACKET);

    logic                          mode_reg;
    logic [LINE_W-1:0]             line_reg, line_next;
    logic [SEG_W-1:0]              seg_reg, seg_next;
    logic                          armed_reg, armed_next;
    logic                          accepted_reg, accepted_next;
    logic [WPOS_W-1:0]             wpos_reg, wpos_next;
    logic [vtpd_pkg::ADDR_W-1:0]   base_reg, base_next;

    vtpd_pkg::verdict_t            verdict;
    logic [WPOS_W-1:0]             wpos_inc;
    logic [WPOS_W-1:0]             pix;
    logic                          pix_hit;
    logic [LINE_W:0]               line_inc;
    logic [SEG_W:0]                seg_inc;

    vtpd_judge #(
        .LINE_W (LINE_W),
        .SEG_W  (SEG_W)
    ) u_judge (
        .packet_id         (item.stream_word),
        .armed             (armed_reg),
        .four_segment_mode (mode_reg),
        .expected_line     (line_reg),
        .current_segment   (seg_reg),
        .verdict           (verdict)
    );

    assign wpos_inc = (wpos_reg < WPOS_W'(PACKET_WORDS)) ? wpos_reg + 1'b1 : wpos_reg;
    assign pix = wpos_inc - WPOS_W'(HEADER_WORDS);
    assign pix_hit = accepted_reg && (wpos_inc >= WPOS_W'(HEADER_WORDS))
                     && (wpos_inc < WPOS_W'(PACKET_WORDS));
    assign line_inc = (LINE_W + 1)'(line_reg) + 1'b1;
    assign seg_inc = (SEG_W + 1)'(seg_reg) + 1'b1;

    always_comb
    begin
        line_next = line_reg;
        seg_next = seg_reg;
        armed_next = armed_reg;
        accepted_next = accepted_reg;
        wpos_next = wpos_reg;
        base_next = base_reg;
        res = '0;
        unique case (item.action)
            vtpd_pkg::ACT_ARM:
            begin
                armed_next = 1'b1;
            end
            vtpd_pkg::ACT_ABORT:
            begin
                armed_next = 1'b0;
                accepted_next = 1'b0;
                wpos_next = '0;
                line_next = '0;
                seg_next = '0;
                base_next = '0;
                res.resync_request = 1'b1;
            end
            vtpd_pkg::ACT_WORD:
            begin
                if (item.packet_start)
                begin
                    wpos_next = '0;
                    accepted_next = verdict.accept;
                    res.resync_request = verdict.resync;
                    if (verdict.clear_all)
                    begin
                        line_next = '0;
                        seg_next = '0;
                        base_next = '0;
                    end
                    else if (verdict.clear_line)
                    begin
                        // only reached with segment zero, so the base is zero too
                        line_next = '0;
                        base_next = '0;
                    end
                end
                else
                begin
                    wpos_next = wpos_inc;
                    if (pix_hit)
                    begin
                        res.pixel_valid = 1'b1;
                        res.pixel_value = item.stream_word;
                        res.pixel_address = base_reg + vtpd_pkg::ADDR_W'(pix);
                        if (pix == WPOS_W'(PIXELS_PER_PACKET - 1))
                        begin
                            accepted_next = 1'b0;
                            if (line_inc < (LINE_W + 1)'(LINES_PER_SEGMENT))
                            begin
                                line_next = line_inc[LINE_W-1:0];
                                base_next = base_reg + LINE_STEP;
                            end
                            else
                            begin
                                line_next = '0;
                                if (mode_reg && (seg_inc < (SEG_W + 1)'(SEGMENTS_PER_FRAME)))
                                begin
                                    seg_next = seg_inc[SEG_W-1:0];
                                    base_next = base_reg + LINE_STEP;
                                end
                                else if (mode_reg)
                                begin
                                    seg_next = '0;
                                    base_next = '0;
                                    armed_next = 1'b0;
                                    res.frame_done = 1'b1;
                                end
                                else
                                begin
                                    // single segment: back to line zero of this segment
                                    base_next = base_reg - SEG_REWIND;
                                    armed_next = 1'b0;
                                    res.frame_done = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        res.capturing = armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            line_reg <= '0;
            seg_reg <= '0;
            armed_reg <= 1'b0;
            accepted_reg <= 1'b0;
            wpos_reg <= '0;
            base_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            if (fire)
            begin
                line_reg <= line_next;
                seg_reg <= seg_next;
                armed_reg <= armed_next;
                accepted_reg <= accepted_next;
                wpos_reg <= wpos_next;
                base_reg <= base_next;
            end
        end
    end

endmodule

// File: rtl/vtpd_checker.sv
// port-level checks on the deframer results, bound to the top level
`timescale 1ns / 1ps

module vtpd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        pixel_valid,
    input logic [vtpd_pkg::ADDR_W-1:0] pixel_address,
    input logic [vtpd_pkg::WORD_W-1:0] pixel_value,
    input logic                        resync_request,
    input logic                        frame_done,
    input logic                        capturing
);

    // the frame ends on its last pixel and capture drops with it
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_done |-> pixel_valid && !capturing)
        else $error("frame_done without last pixel or with capture still on");

    // a pixel and a resync never come from the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(pixel_valid && resync_request))
        else $error("pixel and resync in one result");

    // idle pixel fields read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !pixel_valid |-> (pixel_address == '0) && (pixel_value == '0))
        else $error("pixel fields not zero without a pixel");

    // a pixel is only written while capture is armed in the request before
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && pixel_valid && !frame_done |-> capturing)
        else $error("pixel written outside a capture");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(pixel_address)
        && $stable(pixel_value) && $stable(frame_done) && $stable(capturing))
        else $error("stalled result changed");

endmodule

bind thermal_video_packet_deframer vtpd_checker u_vtpd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .pixel_valid    (result.pixel_valid),
    .pixel_address  (result.pixel_address),
    .pixel_value    (result.pixel_value),
    .resync_request (result.resync_request),
    .frame_done     (result.frame_done),
    .capturing      (result.capturing)
);

// File: dv/deframer_scoreboard.sv
// scoreboard: predicts every deframer result from the observed requests and checks it
`timescale 1ns / 1ps

module deframer_scoreboard
    import vtpd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    vtpd_item_if   stream_mon,
    vtpd_result_if result_mon,
    input  logic   cfg_write_en,
    input  logic   cfg_write_data,
    output int     failures,
    output int     pending,
    output int     pixels_seen,
    output int     frames_seen,
    output int     resyncs_seen
);

    localparam int PKT_PIXELS = 80;
    localparam int SEG_LINES  = 60;
    localparam int FRAME_SEGS = 4;
    localparam int HDR_WORDS  = 2;
    localparam int PKT_WORDS  = HDR_WORDS + PKT_PIXELS;
    localparam int PRINT_CAP  = 40;

    // deframer state as the block should hold it
    logic [5:0] line_due;
    logic [1:0] seg_now;
    logic       armed;
    logic       pkt_taken;
    logic [6:0] word_idx;
    logic       quad_mode;

    result_t due_results[$];
    int      results_seen;

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        failures++;
        if (failures <= PRINT_CAP)
            $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                     results_seen, what, got_v, want_v);
    endtask

    // decide on a packet's first word; returns the resync pulse
    function automatic logic judge_packet_id(input logic [WORD_W-1:0] id);
        logic [ID_LINE_W-1:0] line_no;
        logic [ID_SEG_W-1:0]  seg_id;
        logic                 at_check;
        line_no  = id[ID_LINE_W-1:0];
        seg_id   = id[ID_LINE_W +: ID_SEG_W];
        at_check = quad_mode && (line_no == CHECK_LINE);
        pkt_taken = 1'b0;
        if (!armed)
            return 1'b0;
        if ((id & DONT_CARE_MASK) == DONT_CARE_MASK)
            return 1'b0;
        if (line_due == '0 && line_no != '0)
            return 1'b0;
        // wrong first segment only drops back to waiting for line 0
        if (at_check && seg_now == '0 && seg_id != FIRST_SEG_ID)
        begin
            line_due = '0;
            return 1'b0;
        end
        if (int'(line_no) != int'(line_due) ||
            (at_check && int'(seg_id) != int'(seg_now) + 1))
        begin
            line_due = '0;
            seg_now  = '0;
            return 1'b1;
        end
        pkt_taken = 1'b1;
        return 1'b0;
    endfunction

    // step to the next line; returns 1 when the frame is complete
    function automatic logic close_line();
        if (int'(line_due) < SEG_LINES - 1)
        begin
            line_due++;
            return 1'b0;
        end
        line_due = '0;
        if (quad_mode)
        begin
            if (int'(seg_now) < FRAME_SEGS - 1)
            begin
                seg_now++;
                return 1'b0;
            end
            seg_now = '0;
        end
        armed = 1'b0;
        return 1'b1;
    endfunction

    task automatic deframe_request(input item_t req, output result_t res);
        int pix;
        res = '0;
        case (req.action)
            ACT_ARM:
                armed = 1'b1;
            ACT_ABORT:
            begin
                armed     = 1'b0;
                pkt_taken = 1'b0;
                word_idx  = '0;
                line_due  = '0;
                seg_now   = '0;
                res.resync_request = 1'b1;
            end
            ACT_WORD:
            begin
                if (req.packet_start)
                begin
                    word_idx = '0;
                    res.resync_request = judge_packet_id(req.stream_word);
                end
                else
                begin
                    if (int'(word_idx) < PKT_WORDS)
                        word_idx++;
                    if (pkt_taken && int'(word_idx) >= HDR_WORDS && int'(word_idx) < PKT_WORDS)
                    begin
                        pix = int'(word_idx) - HDR_WORDS;
                        res.pixel_valid   = 1'b1;
                        res.pixel_value   = req.stream_word;
                        res.pixel_address = ADDR_W'((int'(seg_now) * SEG_LINES + int'(line_due))
                                                    * PKT_PIXELS + pix);
                        if (pix == PKT_PIXELS - 1)
                        begin
                            pkt_taken = 1'b0;
                            res.frame_done = close_line();
                        end
                    end
                end
            end
            default: ;
        endcase
        res.capturing = armed;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t   req;
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            line_due     = '0;
            seg_now      = '0;
            armed        = 1'b0;
            pkt_taken    = 1'b0;
            word_idx     = '0;
            quad_mode    = 1'b0;
            due_results.delete();
            failures     = 0;
            pending      = 0;
            results_seen = 0;
            pixels_seen  = 0;
            frames_seen  = 0;
            resyncs_seen = 0;
        end
        else
        begin
            if (cfg_write_en)
                quad_mode = cfg_write_data;
            if (result_mon.valid && result_mon.ready)
            begin
                got.pixel_valid    = result_mon.pixel_valid;
                got.pixel_address  = result_mon.pixel_address;
                got.pixel_value    = result_mon.pixel_value;
                got.resync_request = result_mon.resync_request;
                got.frame_done     = result_mon.frame_done;
                got.capturing      = result_mon.capturing;
                results_seen++;
                if (got.pixel_valid === 1'b1)
                    pixels_seen++;
                if (got.frame_done === 1'b1)
                    frames_seen++;
                if (got.resync_request === 1'b1)
                    resyncs_seen++;
                if (due_results.size() == 0)
                    report_mismatch("result with no request pending",
                                    int'(got.pixel_value), 0);
                else
                begin
                    want = due_results.pop_front();
                    if (got.pixel_valid !== want.pixel_valid)
                        report_mismatch("pixel_valid", int'(got.pixel_valid),
                                        int'(want.pixel_valid));
                    if (got.pixel_address !== want.pixel_address)
                        report_mismatch("pixel_address", int'(got.pixel_address),
                                        int'(want.pixel_address));
                    if (got.pixel_value !== want.pixel_value)
                        report_mismatch("pixel_value", int'(got.pixel_value),
                                        int'(want.pixel_value));
                    if (got.resync_request !== want.resync_request)
                        report_mismatch("resync_request", int'(got.resync_request),
                                        int'(want.resync_request));
                    if (got.frame_done !== want.frame_done)
                        report_mismatch("frame_done", int'(got.frame_done),
                                        int'(want.frame_done));
                    if (got.capturing !== want.capturing)
                        report_mismatch("capturing", int'(got.capturing),
                                        int'(want.capturing));
                end
            end
            if (stream_mon.valid && stream_mon.ready)
            begin
                req.action       = stream_mon.action;
                req.stream_word  = stream_mon.stream_word;
                req.packet_start = stream_mon.packet_start;
                deframe_request(req, want);
                due_results.push_back(want);
            end
            pending = due_results.size();
        end
    end

endmodule

// File: dv/tb_thermal_video_packet_deframer.sv
// testbench top: stimulus, pacing phases and verdict for the packet deframer
`timescale 1ns / 1ps

module tb_thermal_video_packet_deframer;
    import vtpd_pkg::*;

    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int PKT_BODY     = 81;   // words after the packet id
    localparam int ROW_COUNT    = 60;
    localparam int SEG_COUNT    = 4;
    localparam int DRAIN_CYCLES = 4;
    localparam int QUIET_LIMIT  = 1000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en;
    logic cfg_write_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int requests_sent = 0;
    int failures;
    int pending;
    int pixels_seen;
    int frames_seen;
    int resyncs_seen;

    // where the stimulus believes the block stands
    int next_line = 0;
    int next_seg = 0;
    bit armed_hint = 1'b0;
    bit quad = 1'b0;

    vtpd_item_if   stream ();
    vtpd_result_if result ();

    thermal_video_packet_deframer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .stream         (stream),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    deframer_scoreboard scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .stream_mon     (stream),
        .result_mon     (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .failures       (failures),
        .pending        (pending),
        .pixels_seen    (pixels_seen),
        .frames_seen    (frames_seen),
        .resyncs_seen   (resyncs_seen)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write_en || (stream.valid && stream.ready) ||
            (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_request(input logic [1:0] act, input logic [WORD_W-1:0] word,
                                input logic start);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            stream.valid <= 1'b0;
            @(negedge clk);
        end
        stream.valid        <= 1'b1;
        stream.action       <= act;
        stream.stream_word  <= word;
        stream.packet_start <= start;
        @(posedge clk);
        while (!stream.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // drop valid, wait for every pending result, then let the pipeline drain
    task automatic settle();
        @(negedge clk);
        stream.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input bit four_seg);
        settle();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= four_seg;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        quad = four_seg;
    endtask

    function automatic logic [WORD_W-1:0] pixel_word();
        case ($urandom_range(0, 15))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] make_id(input int line_no, input int seg_field);
        return {1'($urandom), 3'(seg_field), 12'(line_no)};
    endfunction

    task automatic send_packet(input logic [WORD_W-1:0] id, input int body_words);
        push_request(ACT_WORD, id, 1'b1);
        for (int k = 0; k < body_words; k++)
        begin
            if ($urandom_range(0, 199) == 0)
                push_request(ACT_IGNORED, 16'($urandom), 1'($urandom));
            push_request(ACT_WORD, pixel_word(), 1'b0);
        end
    endtask

    task automatic advance_line();
        next_line++;
        if (next_line == ROW_COUNT)
        begin
            next_line = 0;
            if (quad)
            begin
                next_seg++;
                if (next_seg == SEG_COUNT)
                begin
                    next_seg = 0;
                    armed_hint = 1'b0;
                end
            end
            else
                armed_hint = 1'b0;
        end
    endtask

    task automatic run_packets(input int packet_total, input int fault_pct);
        int wrong_line;
        int seg_field;
        int roll;
        for (int p = 0; p < packet_total; p++)
        begin
            if (!armed_hint)
            begin
                if ($urandom_range(0, 99) < 15)
                    send_packet(make_id(next_line, next_seg + 1), PKT_BODY);
                push_request(ACT_ARM, 16'($urandom), 1'($urandom));
                armed_hint = 1'b1;
            end
            if (fault_pct > 0 && quad && next_line == int'(CHECK_LINE) &&
                $urandom_range(0, 2) == 0)
            begin
                // segment number at the check line does not match
                do
                    seg_field = $urandom_range(0, 7);
                while (seg_field == next_seg + 1);
                send_packet(make_id(next_line, seg_field), PKT_BODY);
                next_line = 0;
                next_seg = 0;
            end
            else if ($urandom_range(0, 99) < fault_pct)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    do
                        wrong_line = $urandom_range(0, 16'h0EFF);
                    while (wrong_line == next_line);
                    send_packet(make_id(wrong_line, $urandom_range(0, 7)), PKT_BODY);
                    if (next_line != 0)
                    begin
                        next_line = 0;
                        next_seg = 0;
                    end
                end
                else
                begin
                    send_packet(make_id(next_line, next_seg + 1), $urandom_range(0, PKT_BODY));
                    push_request(ACT_ABORT, 16'($urandom), 1'($urandom));
                    next_line = 0;
                    next_seg = 0;
                    armed_hint = 1'b0;
                end
            end
            else
            begin
                roll = $urandom_range(0, 99);
                seg_field = (quad && next_line == int'(CHECK_LINE)) ? next_seg + 1
                                                                    : $urandom_range(0, 7);
                if (roll < 4)
                    send_packet({1'($urandom), 3'($urandom), 4'hF, 8'($urandom)},
                                $urandom_range(0, PKT_BODY));
                else if (roll < 8)
                    send_packet(make_id(next_line, seg_field), $urandom_range(0, PKT_BODY - 1));
                else if (roll < 10)
                    push_request(ACT_ARM, 16'($urandom), 1'($urandom));
                // a few trailing words past the packet end now and then
                send_packet(make_id(next_line, seg_field),
                            PKT_BODY + ((roll >= 90) ? $urandom_range(1, 4) : 0));
                advance_line();
            end
        end
    endtask

    initial
    begin
        stream.valid        = 1'b0;
        stream.action       = ACT_WORD;
        stream.stream_word  = '0;
        stream.packet_start = 1'b0;
        result.ready        = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_write_data      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_mode(1'b0);

        // directed: idle words, ignored action, abort, arming, header rules, truncation
        push_request(ACT_WORD, 16'h0000, 1'b1);
        push_request(ACT_WORD, 16'hFFFF, 1'b0);
        push_request(ACT_IGNORED, 16'hFFFF, 1'b1);
        push_request(ACT_ABORT, 16'h0000, 1'b0);
        push_request(ACT_ARM, 16'h0000, 1'b0);
        push_request(ACT_ARM, 16'hFFFF, 1'b1);
        push_request(ACT_WORD, 16'h0F00, 1'b1);
        push_request(ACT_WORD, 16'h1005, 1'b1);
        push_request(ACT_WORD, 16'h7000, 1'b1);
        push_request(ACT_WORD, 16'hFFFF, 1'b0);
        push_request(ACT_WORD, 16'h0000, 1'b0);
        push_request(ACT_WORD, 16'hFFFF, 1'b0);
        push_request(ACT_IGNORED, 16'h0000, 1'b0);
        push_request(ACT_WORD, 16'h8000, 1'b1);
        push_request(ACT_WORD, 16'h5A5A, 1'b0);
        push_request(ACT_WORD, 16'hA5A5, 1'b0);
        push_request(ACT_ABORT, 16'hFFFF, 1'b1);
        push_request(ACT_WORD, 16'h1234, 1'b0);
        push_request(ACT_ARM, 16'h0000, 1'b0);
        push_request(ACT_WORD, 16'h0001, 1'b1);
        push_request(ACT_WORD, 16'hFFFF, 1'b1);
        armed_hint = 1'b1;
        settle();

        // no idling, single segment: a clean line, then faults
        run_packets(1, 0);
        run_packets(1, 30);

        // four segments, sender idling, with a full drain in the middle
        set_mode(1'b1);
        send_idle_pct = 67;
        run_packets(1, 30);
        settle();
        run_packets(1, 30);

        // receiver stalling
        send_idle_pct = 0;
        recv_stall_pct = 67;
        run_packets(1, 0);

        // both sides idling lightly, back to a single segment
        send_idle_pct = 7;
        recv_stall_pct = 7;
        set_mode(1'b0);
        run_packets(1, 30);

        settle();
        $display("run covered %0d requests: %0d pixels, %0d finished frames, %0d resyncs",
                 requests_sent, pixels_seen, frames_seen, resyncs_seen);
        $display("both segment modes, header faults, aborts and four pacing phases exercised");
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
